/* rtl/core/masked_byte_pattern_scanner_unit_defines.svh */
// Assertion macros for the pattern scanner.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define MBPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MBPS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define MBPS_ASSERT(name, prop, msg)

`define MBPS_ASSERT_NEVER(name, cond, msg)

`endif

`endif

/* rtl/core/mbps_pkg.sv */
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned WindowDepth     = 16;
  localparam int unsigned LenCap          =
      (MaxPatternBytes < WindowDepth) ? MaxPatternBytes : WindowDepth;

  localparam int unsigned AddrWidth     = 48;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned CfgDataWidth  = 64;
  localparam int unsigned CfgIndexWidth = 4;
  localparam int unsigned MaskWidth     = 16;
  localparam int unsigned LenWidth      = 5;
  localparam int unsigned CountWidth    = $clog2(WindowDepth + 1);
  localparam int unsigned WinIdxWidth   = $clog2(WindowDepth);

  localparam logic [MaskWidth-1:0] CareMaskReset = '1;
  localparam logic [LenWidth-1:0]  LenReset      = LenWidth'(1);

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgPatternLow  = 4'd0,
    CfgPatternHigh = 4'd1,
    CfgCareMask    = 4'd2,
    CfgPatternLen  = 4'd3
  } cfg_index_e;

  typedef logic [ByteWidth-1:0] byte_t;
  typedef byte_t [WindowDepth-1:0] window_t;

  // Pattern byte i, byte 0 in the low bits of the low word.
  function automatic byte_t pattern_byte(input logic [CfgDataWidth-1:0] low_word,
                                         input logic [CfgDataWidth-1:0] high_word,
                                         input int unsigned idx);
    logic [2*CfgDataWidth-1:0] both;
    both = {high_word, low_word};
    return both[ByteWidth*idx +: ByteWidth];
  endfunction

endpackage

/* rtl/core/mbps_byte_if.sv */
`timescale 1ns / 1ps

interface mbps_byte_if import mbps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] byte_value;
  logic [AddrWidth-1:0] byte_addr;
  logic                 chunk_first;

  modport source (output valid, output byte_value, output byte_addr, output chunk_first,
                  input ready);
  modport sink   (input valid, input byte_value, input byte_addr, input chunk_first,
                  output ready);
endinterface

/* rtl/core/mbps_match_if.sv */
`timescale 1ns / 1ps

interface mbps_match_if import mbps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AddrWidth-1:0] match_addr;

  modport source (output valid, output match_addr, input ready);
  modport sink   (input valid, input match_addr, output ready);
endinterface

/* rtl/core/mbps_cfg_if.sv */
`timescale 1ns / 1ps

interface mbps_cfg_if import mbps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/masked_byte_pattern_scanner_unit.sv */
// An input transfer reaches its match transfer through the input register, then the result
// register; the window compare sits combinationally between them.
// Throughput: one byte per cycle, sustained while the match side takes results.
// Reset (rst_ni low, asynchronous): window and count clear, pattern bytes to zero,
// care mask to all ones, pattern length to one; no result is pending.
`timescale 1ns / 1ps

`include "masked_byte_pattern_scanner_unit_defines.svh"

module masked_byte_pattern_scanner_unit import mbps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mbps_byte_if.sink    byte_i,
  mbps_cfg_if.sink     cfg_i,
  mbps_match_if.source match_o
);

  // Configuration registers
  logic [CfgDataWidth-1:0] pat_low_q, pat_high_q;
  logic [MaskWidth-1:0]    care_mask_q;
  logic [LenWidth-1:0]     pat_len_q;

  // Input stage
  logic                 s1_valid_q;
  logic [ByteWidth-1:0] s1_byte_q;
  logic [AddrWidth-1:0] s1_addr_q;
  logic                 s1_first_q;

  // Scan state
  window_t               win_q, win_d;
  logic [CountWidth-1:0] count_q, count_d;

  // Result stage
  logic                 out_valid_q;
  logic [AddrWidth-1:0] out_addr_q;

  logic                  s1_adv;
  logic                  in_xfer;
  logic [LenWidth-1:0]   len_eff;
  logic                  hit;
  logic                  found;
  logic [CountWidth-1:0] count_inc;
  logic [AddrWidth-1:0]  start_addr;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q   <= '0;
      pat_high_q  <= '0;
      care_mask_q <= CareMaskReset;
      pat_len_q   <= LenReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgPatternLow:  pat_low_q   <= cfg_i.data;
        CfgPatternHigh: pat_high_q  <= cfg_i.data;
        CfgCareMask:    care_mask_q <= cfg_i.data[MaskWidth-1:0];
        CfgPatternLen:  pat_len_q   <= cfg_i.data[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input stage when the result register is free or drains now.
  assign s1_adv       = s1_valid_q && (!out_valid_q || match_o.ready);
  assign byte_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer      = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      s1_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= byte_i.byte_value;
      s1_addr_q  <= byte_i.byte_addr;
      s1_first_q <= byte_i.chunk_first;
    end
  end

  always_comb begin
    priority if (pat_len_q == '0) begin
      len_eff = LenWidth'(1);
    end else if (pat_len_q > LenWidth'(LenCap)) begin
      len_eff = LenWidth'(LenCap);
    end else begin
      len_eff = pat_len_q;
    end
  end

  // Shift the new byte in; a chunk start drops the old window first.
  always_comb begin
    win_d[0] = s1_byte_q;
    for (int k = 1; k < WindowDepth; k++) begin
      win_d[k] = s1_first_q ? '0 : win_q[k-1];
    end
  end

  always_comb begin
    logic [CountWidth-1:0] base;
    base      = s1_first_q ? '0 : count_q;
    count_inc = (base < CountWidth'(WindowDepth)) ? base + CountWidth'(1) : base;
  end

  // Pattern byte i lines up with the byte received len-1-i steps ago.
  always_comb begin
    logic [LenWidth-1:0] pos;
    hit = 1'b1;
    pos = '0;
    for (int i = 0; i < WindowDepth; i++) begin
      pos = LenWidth'(len_eff - LenWidth'(i) - LenWidth'(1));
      if ((LenWidth'(i) < len_eff) && care_mask_q[i] &&
          (win_d[pos[WinIdxWidth-1:0]] != pattern_byte(pat_low_q, pat_high_q, i))) begin
        hit = 1'b0;
      end
    end
  end

  assign found      = hit && (count_inc >= CountWidth'(len_eff));
  assign count_d    = found ? '0 : count_inc;
  assign start_addr = s1_addr_q - AddrWidth'(len_eff - LenWidth'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      win_q       <= win_d;
      count_q     <= count_d;
      out_valid_q <= found;
    end else if (match_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && found) begin
      out_addr_q <= start_addr;
    end
  end

  assign match_o.valid      = out_valid_q;
  assign match_o.match_addr = out_addr_q;

  `MBPS_ASSERT_NEVER(a_count_bound, count_q > CountWidth'(WindowDepth), "count above window depth")
  `MBPS_ASSERT(a_hit_restarts, (s1_adv && found) |=> (count_q == '0), "count not restarted after match")
  `MBPS_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(s1_valid_q), "result without an item")
  `MBPS_ASSERT(a_empty_ready, !s1_valid_q |-> byte_i.ready, "empty input stage not ready")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mbps_pkg::*;

  typedef logic [AddrWidth-1:0] addr_t;

  typedef enum logic {
    RowByte,
    RowCfg
  } row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIndexWidth-1:0] idx;
    logic [CfgDataWidth-1:0]  data;
    byte_t                    value;
    addr_t                    addr;
    logic                     first;
    logic                     typed;
    logic                     hit;
    addr_t                    exp_addr;
  } stim_row_t;

  localparam int unsigned ItemsPerSetting = 78;
  localparam int unsigned NumSettings     = 9;
  localparam int unsigned PressureSetting = 6;
  localparam int unsigned HoldCycles      = 400;
  localparam int unsigned StallLimit      = 3000;
  localparam int unsigned DrainCycles     = 4;
  localparam logic [CfgIndexWidth-1:0] CfgUnusedIndex = 4'd9;
  localparam addr_t AddrMax = '1;

  logic clk_i;
  logic rst_ni;

  mbps_byte_if  byte_if ();
  mbps_cfg_if   cfg_if ();
  mbps_match_if match_if ();

  masked_byte_pattern_scanner_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .cfg_i   (cfg_if),
    .match_o (match_if)
  );

  logic byte_fire;
  logic cfg_fire;
  logic match_fire;
  assign byte_fire  = byte_if.valid && byte_if.ready;
  assign cfg_fire   = cfg_if.valid && cfg_if.ready;
  assign match_fire = match_if.valid && match_if.ready;

  // Scanner shadow state and register copies
  logic [CfgDataWidth-1:0] sig_lo_q  = '0;
  logic [CfgDataWidth-1:0] sig_hi_q  = '0;
  logic [MaskWidth-1:0]    care_q    = CareMaskReset;
  logic [LenWidth-1:0]     len_q     = LenReset;
  window_t                 win_q     = '0;
  int unsigned             elig_q    = 0;

  addr_t       match_q[$];
  stim_row_t   stim_q[$];
  int unsigned err_cnt      = 0;
  int unsigned src_idle_pct = 20;
  int unsigned snk_idle_pct = 81;
  logic        hold_req     = 1'b0;
  logic        row_typed    = 1'b0;
  logic        row_hit      = 1'b0;
  addr_t       row_exp      = '0;

  function automatic int unsigned eff_len(input logic [LenWidth-1:0] l);
    int unsigned n;
    n = l;
    if (n == 0) n = 1;
    if (n > LenCap) n = LenCap;
    return n;
  endfunction

  function automatic byte_t sig_byte(input logic [CfgDataWidth-1:0] lo,
                                     input logic [CfgDataWidth-1:0] hi,
                                     input int unsigned k);
    return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
  endfunction

  // Advance the window by one byte; return 1 with the start address on a match.
  function automatic logic scan_byte(input byte_t v, input logic f, input addr_t a,
                                     output addr_t start);
    int unsigned len;
    logic        hit;
    start = '0;
    if (f) begin
      win_q  = '0;
      elig_q = 0;
    end
    win_q = {win_q[WindowDepth-2:0], v};
    if (elig_q < WindowDepth) elig_q++;
    len = eff_len(len_q);
    if (elig_q < len) return 1'b0;
    hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (care_q[i] && win_q[len-1-i] != sig_byte(sig_lo_q, sig_hi_q, i)) hit = 1'b0;
    end
    if (hit) begin
      elig_q = 0;
      start  = a - addr_t'(len - 1);
    end
    return hit;
  endfunction

  function automatic void add_byte(input byte_t v, input addr_t a, input logic f,
                                   input logic typed, input logic hit, input addr_t e);
    stim_q.push_back('{RowByte, '0, '0, v, a, f, typed, hit, e});
  endfunction

  function automatic void add_cfg(input logic [CfgIndexWidth-1:0] idx,
                                  input logic [CfgDataWidth-1:0] d);
    stim_q.push_back('{RowCfg, idx, d, '0, '0, 1'b0, 1'b0, 1'b0, '0});
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : monitor
    logic  hit;
    addr_t start;
    addr_t want;
    if (rst_ni) begin
      if (match_fire) begin
        if (match_q.size() == 0) begin
          $error("match_addr: expected none, actual %h", match_if.match_addr);
          err_cnt++;
        end else begin
          want = match_q.pop_front();
          if (match_if.match_addr !== want) begin
            $error("match_addr: expected %h, actual %h", want, match_if.match_addr);
            err_cnt++;
          end
        end
      end
      if (byte_fire) begin
        hit = scan_byte(byte_if.byte_value, byte_if.chunk_first, byte_if.byte_addr, start);
        if (row_typed) begin
          hit   = row_hit;
          start = row_exp;
        end
        if (hit) match_q.push_back(start);
      end
      if (cfg_fire) begin
        case (cfg_if.index)
          CfgPatternLow:  sig_lo_q = cfg_if.data;
          CfgPatternHigh: sig_hi_q = cfg_if.data;
          CfgCareMask:    care_q   = cfg_if.data[MaskWidth-1:0];
          CfgPatternLen:  len_q    = cfg_if.data[LenWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  // Match side: random ready, with one long hold-off on request
  initial begin
    match_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req       = 1'b0;
        match_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      match_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (byte_fire || cfg_fire || match_fire) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input byte_t v, input addr_t a, input logic f);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.byte_value  = v;
    byte_if.byte_addr   = a;
    byte_if.chunk_first = f;
    byte_if.valid       = 1'b1;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] d);
    cfg_if.index = idx;
    cfg_if.data  = d;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop the byte stream, drain pending matches, let the pipeline settle
  task automatic wait_idle();
    byte_if.valid = 1'b0;
    while (match_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [CfgDataWidth-1:0] lo,
                               input logic [CfgDataWidth-1:0] hi,
                               input logic [CfgDataWidth-1:0] mask_word,
                               input logic [CfgDataWidth-1:0] len_word);
    wait_idle();
    cfg_write(CfgPatternLow, lo);
    cfg_write(CfgPatternHigh, hi);
    cfg_write(CfgCareMask, mask_word);
    cfg_write(CfgPatternLen, len_word);
    cfg_if.valid = 1'b0;
  endtask

  initial begin
    logic [CfgDataWidth-1:0] set_lo;
    logic [CfgDataWidth-1:0] set_hi;
    logic [CfgDataWidth-1:0] upper;
    logic [MaskWidth-1:0]    set_mask;
    logic [LenWidth-1:0]     set_len;
    byte_t                   chunk_q[$];
    byte_t                   b;
    addr_t                   base;
    int unsigned             eff;
    int unsigned             sent;
    int unsigned             clen;
    int                      j;

    rst_ni              = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.byte_value  = '0;
    byte_if.byte_addr   = '0;
    byte_if.chunk_first = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;

    // Reset values: pattern zero, every byte cared, length one
    add_byte(8'h00, AddrMax, 1'b1, 1'b1, 1'b1, AddrMax);
    // Length zero behaves as one; an unused register index changes nothing
    add_cfg(CfgPatternLow, '1);
    add_cfg(CfgPatternLen, '0);
    add_cfg(CfgUnusedIndex, '0);
    add_byte(8'hFF, 48'h5, 1'b1, 1'b1, 1'b1, 48'h5);
    add_byte(8'h00, 48'h6, 1'b0, 1'b1, 1'b0, '0);
    // Four bytes 11 22 xx 44; a new chunk drops the partial match
    add_cfg(CfgPatternLow, 64'h0000_0000_4433_2211);
    add_cfg(CfgCareMask, 64'h0000_0000_0000_FFFB);
    add_cfg(CfgPatternLen, 64'd4);
    add_byte(8'h11, 48'h100, 1'b1, 1'b0, 1'b0, '0);
    add_byte(8'h22, 48'h101, 1'b0, 1'b0, 1'b0, '0);
    add_byte(8'h66, 48'h102, 1'b1, 1'b0, 1'b0, '0);
    add_byte(8'h44, 48'h103, 1'b0, 1'b0, 1'b0, '0);
    add_byte(8'h11, 48'h104, 1'b0, 1'b0, 1'b0, '0);
    add_byte(8'h22, 48'h105, 1'b0, 1'b0, 1'b0, '0);
    add_byte(8'h99, 48'h106, 1'b0, 1'b0, 1'b0, '0);
    add_byte(8'h44, 48'h107, 1'b0, 1'b0, 1'b0, '0);
    // Oversized length caps at sixteen, all wildcard; the start address wraps
    add_cfg(CfgCareMask, '0);
    add_cfg(CfgPatternLen, 64'd31);
    for (int k = 0; k < 16; k++) begin
      add_byte(byte_t'(k * 17), 48'hFFFF_FFFF_FFF6 + addr_t'(k), k == 0, 1'b1, k == 15,
               48'hFFFF_FFFF_FFF6);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_q[r]) begin
      if (stim_q[r].kind == RowCfg) begin
        wait_idle();
        cfg_write(stim_q[r].idx, stim_q[r].data);
        cfg_if.valid = 1'b0;
      end else begin
        row_typed = stim_q[r].typed;
        row_hit   = stim_q[r].hit;
        row_exp   = stim_q[r].exp_addr;
        send_byte(stim_q[r].value, stim_q[r].addr, stim_q[r].first);
      end
    end
    row_typed = 1'b0;

    for (int s = 0; s < NumSettings; s++) begin
      set_lo   = {$urandom, $urandom};
      set_hi   = {$urandom, $urandom};
      set_mask = (s == 0 || $urandom_range(2) == 0) ? '1 : MaskWidth'($urandom);
      case (s)
        0:               set_len = LenWidth'(16);
        1:               set_len = LenWidth'(1);
        2:               set_len = '0;
        3:               set_len = '1;
        PressureSetting: begin
          set_len  = LenWidth'(1);
          set_mask = '0;
        end
        default:         set_len = LenWidth'($urandom_range(1, 16));
      endcase
      if (s < 3) begin
        src_idle_pct = 20;
        snk_idle_pct = 81;
      end else if (s < PressureSetting) begin
        src_idle_pct = 81;
        snk_idle_pct = 20;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      upper = {$urandom, $urandom};
      load_settings(set_lo, set_hi, {upper[63:MaskWidth], set_mask},
                    {upper[63:LenWidth], set_len});
      // Every byte matches here, so a held-off match side backs up the input
      if (s == PressureSetting) hold_req = 1'b1;
      eff  = eff_len(set_len);
      sent = 0;
      while (sent < ItemsPerSetting) begin
        chunk_q.delete();
        clen = $urandom_range(1, 48);
        while (chunk_q.size() < clen) begin
          if ($urandom_range(99) < 45) begin
            for (int k = 0; k < eff; k++) begin
              b = set_mask[k] ? sig_byte(set_lo, set_hi, k) : byte_t'($urandom);
              chunk_q.push_back(b);
            end
            if ($urandom_range(9) == 0) begin
              j = chunk_q.size() - 1 - $urandom_range(eff - 1);
              chunk_q[j] = chunk_q[j] ^ (8'h01 << $urandom_range(7));
            end
          end else begin
            repeat ($urandom_range(1, 5)) begin
              if ($urandom_range(2) == 0) b = byte_t'($urandom);
              else b = sig_byte(set_lo, set_hi, $urandom_range(eff - 1));
              chunk_q.push_back(b);
            end
          end
        end
        base = addr_t'({$urandom, $urandom});
        for (j = 0; j < clen; j++) begin
          if (j != 0 && $urandom_range(99) < 3) base = addr_t'({$urandom, $urandom});
          send_byte(chunk_q[j], base, j == 0);
          base++;
          sent++;
        end
      end
    end

    byte_if.valid = 1'b0;
    while (match_q.size() != 0) @(negedge clk_i);
    repeat (2 * DrainCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
